[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication
`define CHK_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[design/psnr_pkg.sv]
`timescale 1ns / 1ps

package psnr_pkg;

    localparam int PIX_W   = 8;
    localparam int ERR_W   = 37;
    localparam int DIV_W   = 3;
    localparam int PSNR_W  = 15;
    localparam int M_W     = 31;          // Q1.30 mantissa
    localparam int SQ_W    = 2 * M_W;
    localparam int FRAC_W  = 24;          // log2 fraction bits
    localparam int ITER_W  = $clog2(FRAC_W);
    localparam int K_W     = 18;

    localparam logic [15:0]       PEAK_SQ      = 16'd65025;
    localparam logic [K_W-1:0]    TEN_LOG2_Q16 = 18'd197283;   // 10*log10(2) in Q16
    localparam logic [PSNR_W-1:0] PSNR_MAX     = 15'h7FFF;

    typedef enum logic [3:0] {
        S_ACCUM,
        S_PROD1,
        S_PROD2,
        S_LOAD,
        S_NORM,
        S_ITER,
        S_SAVE,
        S_DIFF,
        S_SCALE,
        S_ROUND,
        S_OUT
    } psnr_state_t;

    typedef struct packed {
        logic accum;
        logic prod1;
        logic prod2;
        logic load;
        logic sel_err;
        logic norm;
        logic iter;
        logic save_ln;
        logic diff;
        logic scale;
        logic round;
        logic res_zero;
        logic res_ident;
        logic emit;
    } psnr_cmd_t;

    typedef struct packed {
        logic err_zero;
        logic num_zero;
        logic x_top;
        logic out_free;
    } psnr_sts_t;

endpackage

[design/psnr_ctrl.sv]
`timescale 1ns / 1ps

module psnr_ctrl
    import psnr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_last,
    output logic      in_ready,
    input  psnr_sts_t sts,
    output psnr_cmd_t cmd
);

    psnr_state_t       state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              phase_reg, phase_next;   // 0: numerator, 1: error sum

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACCUM;
            iter_reg  <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        phase_next = phase_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_ACCUM:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accum = 1'b1;
                    if (in_last)
                        state_next = S_PROD1;
                end
            end
            S_PROD1:
            begin
                cmd.prod1 = 1'b1;
                if (sts.err_zero)
                begin
                    cmd.res_zero  = 1'b1;
                    cmd.res_ident = 1'b1;
                    state_next    = S_OUT;
                end
                else
                    state_next = S_PROD2;
            end
            S_PROD2:
            begin
                cmd.prod2  = 1'b1;
                phase_next = 1'b0;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.sel_err = phase_reg;
                if (!phase_reg && sts.num_zero)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.load   = 1'b1;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                cmd.norm = 1'b1;
                if (sts.x_top)
                begin
                    iter_next  = '0;
                    state_next = S_ITER;
                end
            end
            S_ITER:
            begin
                cmd.iter = 1'b1;
                if (iter_reg == ITER_W'(FRAC_W - 1))
                    state_next = phase_reg ? S_DIFF : S_SAVE;
                else
                    iter_next = iter_reg + 1'b1;
            end
            S_SAVE:
            begin
                cmd.save_ln = 1'b1;
                phase_next  = 1'b1;
                state_next  = S_LOAD;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_ACCUM;
                end
            end
            default:
            begin
                state_next = S_ACCUM;
            end
        endcase
    end

endmodule

[design/psnr_datapath.sv]
`timescale 1ns / 1ps

module psnr_datapath
    import psnr_pkg::*;
#(
    parameter int COUNT_BITS = 20
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  psnr_cmd_t         cmd,
    output psnr_sts_t         sts,
    input  logic [PIX_W-1:0]  pixel_a,
    input  logic [PIX_W-1:0]  pixel_b,
    input  logic [DIV_W-1:0]  channel_divisor,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PSNR_W-1:0] out_psnr,
    output logic              out_ident
);

    localparam int CNT_W  = COUNT_BITS + 1;
    localparam int PM_W   = CNT_W + 16;
    localparam int NUM_W  = PM_W + DIV_W;
    localparam int X_W    = (NUM_W > ERR_W) ? NUM_W : ERR_W;
    localparam int E_W    = $clog2(X_W);
    localparam int LOG_W  = E_W + FRAC_W;
    localparam int PROD_W = LOG_W + K_W;
    localparam int V_W    = PROD_W - 31;

    logic [ERR_W-1:0]  err_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PM_W-1:0]   prod1_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [X_W-1:0]    x_reg;
    logic [E_W-1:0]    e_reg;
    logic [M_W-1:0]    m_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [LOG_W-1:0]  ln_reg;
    logic [LOG_W-1:0]  diff_reg;
    logic [PROD_W-1:0] scale_reg;
    logic [PSNR_W-1:0] res_psnr_reg;
    logic              res_ident_reg;
    logic              out_valid_reg;
    logic [PSNR_W-1:0] out_psnr_reg;
    logic              out_ident_reg;

    logic [PIX_W-1:0]  absdiff;
    logic [2*PIX_W-1:0] sqdiff;
    logic [ERR_W:0]    err_sum;
    logic [SQ_W-1:0]   msq;
    logic [M_W:0]      mt;
    logic [LOG_W-1:0]  log_cur;
    logic [PROD_W:0]   rsum;
    logic [V_W-1:0]    v;
    logic [PSNR_W-1:0] psnr_sat;

    always_comb
    begin
        absdiff  = (pixel_a > pixel_b) ? (pixel_a - pixel_b) : (pixel_b - pixel_a);
        sqdiff   = (2*PIX_W)'(absdiff) * (2*PIX_W)'(absdiff);
        err_sum  = {1'b0, err_reg} + (ERR_W+1)'(sqdiff);
        msq      = SQ_W'(m_reg) * SQ_W'(m_reg);
        mt       = msq[SQ_W-1:M_W-1];
        log_cur  = {e_reg, frac_reg};
        rsum     = {1'b0, scale_reg} + {{(PROD_W-31){1'b0}}, 1'b1, 31'b0};
        v        = rsum[PROD_W:32];
        psnr_sat = (v > V_W'(PSNR_MAX)) ? PSNR_MAX : v[PSNR_W-1:0];
    end

    // accumulators and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accum)
            begin
                err_reg <= err_sum[ERR_W] ? {ERR_W{1'b1}} : err_sum[ERR_W-1:0];
                if (!count_reg[COUNT_BITS])
                    count_reg <= count_reg + 1'b1;
            end
            else if (cmd.emit)
            begin
                err_reg   <= '0;
                count_reg <= '0;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prod1)
            prod1_reg <= PM_W'(count_reg) * PM_W'(PEAK_SQ);
        if (cmd.prod2)
            num_reg <= NUM_W'(prod1_reg) * NUM_W'(channel_divisor);
        if (cmd.load)
        begin
            x_reg <= cmd.sel_err ? X_W'(err_reg) : X_W'(num_reg);
            e_reg <= E_W'(X_W - 1);
        end
        else if (cmd.norm)
        begin
            if (x_reg[X_W-1])
            begin
                m_reg    <= x_reg[X_W-1 -: M_W];
                frac_reg <= '0;
            end
            else
            begin
                x_reg <= {x_reg[X_W-2:0], 1'b0};
                e_reg <= e_reg - 1'b1;
            end
        end
        if (cmd.iter)
        begin
            m_reg    <= mt[M_W] ? mt[M_W:1] : mt[M_W-1:0];
            frac_reg <= {frac_reg[FRAC_W-2:0], mt[M_W]};
        end
        if (cmd.save_ln)
            ln_reg <= log_cur;
        if (cmd.diff)
            diff_reg <= (ln_reg > log_cur) ? (ln_reg - log_cur) : '0;
        if (cmd.scale)
            scale_reg <= PROD_W'(diff_reg) * PROD_W'(TEN_LOG2_Q16);
        if (cmd.res_zero)
        begin
            res_psnr_reg  <= '0;
            res_ident_reg <= cmd.res_ident;
        end
        else if (cmd.round)
        begin
            res_psnr_reg  <= psnr_sat;
            res_ident_reg <= 1'b0;
        end
        if (cmd.emit)
        begin
            out_psnr_reg  <= res_psnr_reg;
            out_ident_reg <= res_ident_reg;
        end
    end

    assign sts.err_zero = (err_reg == '0);
    assign sts.num_zero = (num_reg == '0);
    assign sts.x_top    = x_reg[X_W-1];
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_psnr  = out_psnr_reg;
    assign out_ident = out_ident_reg;

endmodule

[design/psnr_image_compare.sv]
// Throughput: one pixel item per cycle while summing; input stalls during the final evaluation.
// After the last item: identical images go straight to the result, a zero divisor after the
// numerator check; else numerator and error sum are each normalized (at most X_W-1 shifts,
// X_W = max(COUNT_BITS+20, 37)) and run through the shared 24-step squaring log2 unit in turn.
// Reset (rst_n, async, active low): sums and count cleared, channel_divisor = 1, no result.
`timescale 1ns / 1ps

module psnr_image_compare
    import psnr_pkg::*;
#(
    parameter int COUNT_BITS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] pixel_a, [15:8] pixel_b
    input  logic        s_axis_tlast,   // last_pixel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [14:0] psnr_db, [15] zero
    output logic        m_axis_tuser    // identical
);

    logic [DIV_W-1:0]  divisor_reg;
    psnr_cmd_t         cmd;
    psnr_sts_t         sts;
    logic [PSNR_W-1:0] out_psnr;
    logic              cfg_wr;

    assign cfg_wr = psel && penable && pwrite && !paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            divisor_reg <= DIV_W'(1);
        else if (cfg_wr)
            divisor_reg <= pwdata[DIV_W-1:0];
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-DIV_W){1'b0}}, divisor_reg};

    psnr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    psnr_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .pixel_a         (s_axis_tdata[7:0]),
        .pixel_b         (s_axis_tdata[15:8]),
        .channel_divisor (divisor_reg),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_psnr        (out_psnr),
        .out_ident       (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, out_psnr};

endmodule

[design/psnr_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psnr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    `CHK_IMPLY(a_ident_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 16'd0, "identical result with nonzero psnr")
    `CHK_IMPLY(a_pad_zero, clk, rst_n, m_axis_tvalid, !m_axis_tdata[15], "psnr above Q7.8 range")
    `CHK_NEXT(a_last_stall, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "item taken during evaluation")
    `CHK_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind psnr_image_compare psnr_checker u_chk (.*);

[sim/psnr_frame_checker.sv]
`timescale 1ns / 1ps

module psnr_frame_checker
    import psnr_pkg::*;
#(
    parameter int COUNT_BITS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] pixel_a, [15:8] pixel_b
    input  logic        s_axis_tlast,   // last_pixel
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [14:0] psnr_db, [15] zero
    input  logic        m_axis_tuser,   // identical
    output int          fails,
    output int          pending
);

    localparam int               DIV_IDX  = 0;
    localparam logic [ERR_W-1:0] ERR_SAT  = {ERR_W{1'b1}};
    localparam logic [63:0]      HALF_LSB = 64'h8000_0000;

    typedef struct packed {
        logic [PSNR_W-1:0] psnr_db;
        logic              identical;
    } psnr_result_t;

    psnr_result_t          psnr_due[$];
    logic [DIV_W-1:0]      divisor   = 3'd1;
    logic [ERR_W-1:0]      sse       = '0;
    logic [COUNT_BITS:0]   pix_count = '0;

    // log2 in Q.24 by repeated squaring of a Q1.30 mantissa
    function automatic logic [63:0] log2_fixed(input logic [63:0] x);
        int          e;
        int          i;
        logic [63:0] m;
        logic [63:0] frac;
        e = 0;
        while (e < 63 && (x >> (e + 1)) != 0)
            e++;
        if (e > 30)
            m = x >> (e - 30);
        else
            m = x << (30 - e);
        frac = '0;
        for (i = 0; i < FRAC_W; i++)
        begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= HALF_LSB)
            begin
                frac[0] = 1'b1;
                m       = m >> 1;
            end
        end
        m = 64'(e);
        return (m << FRAC_W) | frac;
    endfunction

    function automatic psnr_result_t frame_psnr(input logic [ERR_W-1:0] err,
                                                input logic [COUNT_BITS:0] n,
                                                input logic [DIV_W-1:0] div);
        psnr_result_t r;
        logic [63:0]  num;
        logic [63:0]  n64;
        logic [63:0]  d64;
        logic [63:0]  ln;
        logic [63:0]  ld;
        logic [63:0]  diff;
        logic [63:0]  v;
        r.psnr_db   = '0;
        r.identical = 1'b0;
        if (err == 0)
            r.identical = 1'b1;
        else
        begin
            n64 = 64'(n);
            d64 = 64'(div);
            num = n64 * d64;
            num = num * PEAK_SQ;
            if (num != 0)
            begin
                ln = log2_fixed(num);
                ld = log2_fixed(64'(err));
                if (ln > ld)
                begin
                    diff = ln - ld;
                    v    = (diff * TEN_LOG2_Q16 + HALF_LSB) >> 32;
                    r.psnr_db = (v > PSNR_MAX) ? PSNR_MAX : v[PSNR_W-1:0];
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] d;
        logic [15:0]      sq;
        psnr_result_t     want;
        if (!rst_n)
        begin
            fails     = 0;
            divisor   = 3'd1;
            sse       = '0;
            pix_count = '0;
            psnr_due.delete();
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite && (paddr >> 2) == DIV_IDX)
                    divisor = pwdata[DIV_W-1:0];
                else if (!pwrite && (paddr >> 2) == DIV_IDX && prdata !== 32'(divisor))
                begin
                    fails++;
                    $display("%0t: divisor read expected %0d got %h", $time, divisor, prdata);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                a  = s_axis_tdata[7:0];
                b  = s_axis_tdata[15:8];
                d  = (a > b) ? a - b : b - a;
                sq = 16'(d) * 16'(d);
                if (sse > ERR_SAT - sq)
                    sse = ERR_SAT;
                else
                    sse = sse + sq;
                if (pix_count < (1 << COUNT_BITS))
                    pix_count = pix_count + 1'b1;
                if (s_axis_tlast)
                begin
                    psnr_due.insert(psnr_due.size(), frame_psnr(sse, pix_count, divisor));
                    sse       = '0;
                    pix_count = '0;
                end
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (psnr_due.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result expected none got tdata=%h tuser=%b",
                             $time, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = psnr_due.pop_front();
                    if (m_axis_tdata !== {1'b0, want.psnr_db})
                    begin
                        fails++;
                        $display("%0t: psnr_db expected %h got %h", $time,
                                 {1'b0, want.psnr_db}, m_axis_tdata);
                    end
                    if (m_axis_tuser !== want.identical)
                    begin
                        fails++;
                        $display("%0t: identical expected %b got %b", $time,
                                 want.identical, m_axis_tuser);
                    end
                end
            end
        end
        pending <= psnr_due.size();
    end

endmodule

[sim/psnr_image_compare_tb.sv]
`timescale 1ns / 1ps

module psnr_image_compare_tb
    import psnr_pkg::*;
();

    localparam int         COUNT_BITS     = 20;
    localparam logic [2:0] DIV_ADDR       = 3'd0;
    localparam logic [2:0] SPARE_ADDR     = 3'd4;
    localparam int         DRAIN_CYCLES   = 200;
    localparam int         HOLD_CYCLES    = 400;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         PHASES         = 8;
    localparam int         PHASE_ITEMS    = 95;

    typedef enum int {
        FR_SAME,
        FR_NEAR,
        FR_FAR,
        FR_EDGE
    } frame_kind_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    int          mism_cnt;
    int          due_cnt;
    int          quiet = 0;
    int          hold_reqs = 0;
    bit          src_gaps = 0;
    bit          sink_gaps = 0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    psnr_image_compare #(.COUNT_BITS(COUNT_BITS)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    psnr_frame_checker #(.COUNT_BITS(COUNT_BITS)) u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fails         (mism_cnt),
        .pending       (due_cnt)
    );

    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // result sink: random stalls plus one long hold-off on request
    initial
    begin
        int gap;
        int hold_seen;
        gap       = 0;
        hold_seen = 0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                gap       = HOLD_CYCLES;
            end
            else if (gap == 0 && sink_gaps && $urandom_range(0, 4) == 0)
                gap = idle_len();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                gap--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic [7:0] a, input logic [7:0] b, input logic last);
        int gap;
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = idle_len();
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (due_cnt != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_divisor(input logic [DIV_W-1:0] v);
        settle();
        apb_access(1'b1, DIV_ADDR, 32'(v));
        apb_access(1'b0, DIV_ADDR, 32'd0);
    endtask

    task automatic send_frame(input int len, input frame_kind_t kind);
        logic [7:0] a;
        logic [7:0] b;
        int         t;
        int         k;
        for (k = 0; k < len; k++)
        begin
            a = 8'($urandom_range(0, 255));
            case (kind)
                FR_SAME: b = a;
                FR_NEAR:
                begin
                    t = int'(a);
                    t = t + int'($urandom_range(0, 6)) - 3;
                    b = (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : t[7:0];
                end
                FR_FAR: b = 8'($urandom_range(0, 255));
                default:
                begin
                    a = ($urandom_range(0, 2) == 0) ? a : ($urandom_range(0, 1) ? 8'hFF : 8'h00);
                    b = ($urandom_range(0, 1) ? 8'hFF : 8'h00);
                end
            endcase
            send_pixel(a, b, k == len - 1);
        end
    endtask

    initial
    begin
        int          ph;
        int          in_phase;
        int          len;
        frame_kind_t kind;
        logic [DIV_W-1:0] div_plan [PHASES];
        div_plan = '{3'd2, 3'd1, 3'd3, 3'd4, 3'd5, 3'd0, 3'd7, 3'd6};

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset divisor of one
        send_pixel(8'h00, 8'h00, 1'b1);     // identical
        send_pixel(8'hFF, 8'h00, 1'b1);     // ratio exactly one
        send_pixel(8'h00, 8'hFF, 1'b1);
        send_pixel(8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'h00, 1'b0);
        send_pixel(8'h01, 8'h00, 1'b0);
        send_pixel(8'h80, 8'h7F, 1'b1);
        send_pixel(8'hAA, 8'h55, 1'b0);
        send_pixel(8'h55, 8'hAA, 1'b1);

        set_divisor(3'd4);
        send_pixel(8'h0A, 8'h0C, 1'b1);
        send_pixel(8'h00, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'h00, 1'b1);

        set_divisor(3'd0);                  // numerator of zero
        send_pixel(8'h03, 8'h09, 1'b1);
        send_pixel(8'h07, 8'h07, 1'b1);

        set_divisor(3'd7);
        send_pixel(8'hC8, 8'h64, 1'b0);
        send_pixel(8'h37, 8'hAA, 1'b1);
        settle();
        apb_access(1'b1, SPARE_ADDR, 32'd2);  // unmapped index, ignored
        apb_access(1'b0, DIV_ADDR, 32'd0);
        send_pixel(8'h01, 8'h02, 1'b1);

        for (ph = 0; ph < PHASES; ph++)
        begin
            set_divisor(div_plan[ph]);
            src_gaps  = (ph == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            sink_gaps = (ph == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (ph == 1)
                hold_reqs++;
            in_phase = 0;
            while (in_phase < PHASE_ITEMS)
            begin
                if (ph == 1)
                    len = $urandom_range(1, 3);
                else
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                      : $urandom_range(1, 16);
                kind = frame_kind_t'($urandom_range(0, 3));
                send_frame(len, kind);
                in_phase += len;
            end
        end

        settle();
        if (mism_cnt == 0 && due_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/psnr_pkg.sv
design/psnr_ctrl.sv
design/psnr_datapath.sv
design/psnr_image_compare.sv
design/psnr_checker.sv
sim/psnr_frame_checker.sv
sim/psnr_image_compare_tb.sv
